>>> rtl/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

	localparam int KEY_W        = 64;
	localparam int VAL_W        = 64;
	localparam int CAPACITY_DEF = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Command broadcast from the control logic to every cell of the row.
	typedef struct packed {
		logic             ins_en;
		logic             look_en;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/skvt_if.sv
`default_nettype none

interface skvt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [skvt_pkg::KEY_W-1:0]  key;
	logic [skvt_pkg::VAL_W-1:0]  value;

	modport source (output valid, opcode, key, value, input ready);
	modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface skvt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [skvt_pkg::VAL_W-1:0]  read_value;
	logic                        table_full;

	modport source (output valid, found, read_value, table_full, input ready);
	modport sink   (input valid, found, read_value, table_full, output ready);
endinterface

`default_nettype wire

>>> rtl/skvt_cell.sv
`default_nettype none

module skvt_cell (
	input  wire                         clk,
	input  wire                         occ,
	input  skvt_pkg::cmd_t              cmd,
	input  wire [skvt_pkg::KEY_W-1:0]   left_key,
	input  wire [skvt_pkg::VAL_W-1:0]   left_value,
	input  wire                         left_ge,
	input  wire                         left_lt,
	output logic [skvt_pkg::KEY_W-1:0]  key_q,
	output logic [skvt_pkg::VAL_W-1:0]  value_q,
	output logic                        ge,
	output logic                        lt,
	output logic                        hit_q,
	output logic [skvt_pkg::VAL_W-1:0]  hit_value_q
);
	import skvt_pkg::*;

	logic eq;

	// An empty cell counts as greater so that the new pair lands in the first free slot.
	assign ge = !occ || (key_q > cmd.key);
	assign lt = occ && (key_q < cmd.key);
	assign eq = occ && (key_q == cmd.key);

	always_ff @(posedge clk) begin
		if (cmd.ins_en && ge) begin
			if (left_ge) begin
				key_q   <= left_key;
				value_q <= left_value;
			end else begin
				key_q   <= cmd.key;
				value_q <= cmd.value;
			end
		end
		// The first matching cell is the one whose left neighbor holds a smaller key.
		if (cmd.look_en) begin
			hit_q       <= eq && left_lt;
			hit_value_q <= (eq && left_lt) ? value_q : '0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sorted_key_value_table_top.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   opcode, key[63:0], value[63:0]
// rsp      out  valid/ready   found, read_value[63:0], table_full
//
// An insert writes the row of cells unless the table is full, and loads its result
// in the cycle it is accepted; a lookup registers the compare in every cell, then
// loads the OR of the one-hot match into the output register. Inserts run at one
// item per cycle while the output is not stalled. Reset clears the fill count, the
// lookup flag and the output valid; the cells hold their contents. req.ready drops
// while a result waits untaken in the output register or a lookup reduces.
`default_nettype none

module sorted_key_value_table_top #(
	parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
	input wire          clk,
	input wire          arst_n,
	skvt_req_if.sink    req,
	skvt_rsp_if.source  rsp
);
	import skvt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]    count_q;
	logic             look_q;
	logic             accept;
	logic             full;
	cmd_t             cmd;

	logic             rsp_valid_q;
	logic             found_q;
	logic [VAL_W-1:0] read_value_q;
	logic             table_full_q;

	logic [KEY_W-1:0] cell_key   [CAPACITY];
	logic [VAL_W-1:0] cell_value [CAPACITY];
	logic [VAL_W-1:0] cell_hitv  [CAPACITY];
	logic [CAPACITY-1:0] cell_ge;
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_hit;
	logic [CAPACITY-1:0] cell_occ;

	logic [VAL_W-1:0] hit_or;

	// One item at a time: no new item during the reduce cycle of a lookup, and
	// only when the output register is free or drains in this cycle.
	assign req.ready = !look_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));

	always_comb begin
		cmd.ins_en  = accept && (req.opcode == OP_INSERT) && !full;
		cmd.look_en = accept && (req.opcode == OP_LOOKUP);
		cmd.key     = req.key;
		cmd.value   = req.value;
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			// Occupied slots form a prefix of the row.
			assign cell_occ[i] = (count_q > CW'(i));

			if (i == 0) begin : g_head
				skvt_cell u_cell (
					.clk         (clk),
					.occ         (cell_occ[i]),
					.cmd         (cmd),
					.left_key    (req.key),
					.left_value  (req.value),
					.left_ge     (1'b0),
					.left_lt     (1'b1),
					.key_q       (cell_key[i]),
					.value_q     (cell_value[i]),
					.ge          (cell_ge[i]),
					.lt          (cell_lt[i]),
					.hit_q       (cell_hit[i]),
					.hit_value_q (cell_hitv[i])
				);
			end else begin : g_body
				skvt_cell u_cell (
					.clk         (clk),
					.occ         (cell_occ[i]),
					.cmd         (cmd),
					.left_key    (cell_key[i-1]),
					.left_value  (cell_value[i-1]),
					.left_ge     (cell_ge[i-1]),
					.left_lt     (cell_lt[i-1]),
					.key_q       (cell_key[i]),
					.value_q     (cell_value[i]),
					.ge          (cell_ge[i]),
					.lt          (cell_lt[i]),
					.hit_q       (cell_hit[i]),
					.hit_value_q (cell_hitv[i])
				);
			end
		end
	endgenerate

	// At most one cell reports a hit and the others hold zero, so an OR picks it.
	always_comb begin
		hit_or = '0;
		for (int n = 0; n < CAPACITY; n++) begin
			hit_or = hit_or | cell_hitv[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			look_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_en) begin
				count_q <= count_q + CW'(1);
			end
			look_q <= cmd.look_en;
			if (accept && (req.opcode == OP_INSERT)) begin
				rsp_valid_q <= 1'b1;
			end else if (look_q) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.opcode == OP_INSERT)) begin
			found_q      <= 1'b0;
			read_value_q <= '0;
			table_full_q <= full;
		end else if (look_q) begin
			found_q      <= |cell_hit;
			read_value_q <= hit_or;
			table_full_q <= 1'b0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;
	assign rsp.table_full = table_full_q;

endmodule

`default_nettype wire

>>> rtl/skvt_checker.sv
`default_nettype none

module skvt_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        req_valid,
	input wire                        req_ready,
	input wire                        req_opcode,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire                        rsp_found,
	input wire [skvt_pkg::VAL_W-1:0]  rsp_read_value,
	input wire                        rsp_table_full
);
	import skvt_pkg::*;

	// A stalled result holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
		else $error("stalled result changed");

	// A miss or an insert always reports a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_read_value == '0)
		else $error("nonzero value without a hit");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_table_full))
		else $error("hit and full flagged together");

	// An insert result is in the output register in the cycle after acceptance.
	a_ins_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == OP_INSERT |=> rsp_valid && !rsp_found)
		else $error("insert result missing");

	// A lookup blocks the next item for its reduce cycle.
	a_look_block: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == OP_LOOKUP |=> !req_ready)
		else $error("item accepted during lookup");

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_opcode     (req.opcode),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_read_value (rsp.read_value),
	.rsp_table_full (rsp.table_full)
);

`default_nettype wire
